>>> hw/rtl/psgd_pkg.sv
package psgd_pkg;

  localparam int POS_W      = 20;
  localparam int TIME_W     = 32;
  localparam int SENS_W     = 4;
  localparam int WIN_W      = 10;
  localparam int LEG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int NEAR_W     = 5;
  localparam int DSQ_W      = 2 * NEAR_W + 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

  localparam logic              EN_RST   = 1'b1;
  localparam logic [SENS_W-1:0] SENS_RST = 4'd5;
  localparam logic [WIN_W-1:0]  WIN_RST  = 10'd400;

  localparam logic [SENS_W-1:0] SENS_MIN = 4'd1;
  localparam logic [SENS_W-1:0] SENS_MAX = 4'd10;
  localparam logic [WIN_W-1:0]  WIN_MIN  = 10'd150;
  localparam logic [WIN_W-1:0]  WIN_MAX  = 10'd1000;

  localparam int AGE_MS          = 1000;
  localparam int NEAR_LIM        = 1 << NEAR_W;   // 2 px in 1/16 px
  localparam int DIST_SQ         = 1024;          // (2 px)^2 in (1/16 px)^2
  localparam int MIN_WIN_SAMPLES = 4;
  localparam int MIN_REVS        = 2;

  // minimum leg per sensitivity, in 1/144 px
  localparam logic [LEG_W-1:0] LEG_TABLE [10] = '{
    13'd7776, 13'd7136, 13'd6496, 13'd5856, 13'd5216,
    13'd4576, 13'd3936, 13'd3296, 13'd2656, 13'd2016
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_NEWEST,
    ST_DIST,
    ST_PRUNE,
    ST_APPEND,
    ST_WIN0,
    ST_WIN,
    ST_SPAN0,
    ST_SPAN,
    ST_TRK0,
    ST_TRK,
    ST_EVAL,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef struct packed {
    logic span;    // span pass step
    logic trk;     // tracker pass step
    logic first;   // this word is the first window sample
  } axis_ctl_t;

  function automatic logic [LEG_W-1:0] leg_of(input logic [SENS_W-1:0] s);
    logic [SENS_W-1:0] c;
    c = s;
    if (c < SENS_MIN) c = SENS_MIN;
    if (c > SENS_MAX) c = SENS_MAX;
    return LEG_TABLE[c - SENS_MIN];
  endfunction

  function automatic logic [WIN_W-1:0] win_clamp(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] c;
    c = w;
    if (c < WIN_MIN) c = WIN_MIN;
    if (c > WIN_MAX) c = WIN_MAX;
    return c;
  endfunction

endpackage

>>> hw/rtl/psgd_if.sv
interface psgd_in_if;
  import psgd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [TIME_W-1:0]       time_ms;
  logic                    eligible;
  modport source (output valid, command, pos_x, pos_y, time_ms, eligible, input ready);
  modport sink (input valid, command, pos_x, pos_y, time_ms, eligible, output ready);
endinterface

interface psgd_out_if;
  logic valid;
  logic ready;
  logic shake_detected;
  modport source (output valid, shake_detected, input ready);
  modport sink (input valid, shake_detected, output ready);
endinterface

interface psgd_cfg_if;
  import psgd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/psgd_ram.sv
module psgd_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/psgd_axis.sv
module psgd_axis #(
  parameter int MAX_SAMPLES = 48
) (
  input  logic                              clk,
  input  psgd_pkg::axis_ctl_t               ctl,
  input  logic signed [psgd_pkg::POS_W-1:0] v,
  input  logic [psgd_pkg::LEG_W-1:0]        leg,
  output logic                              ok
);
  import psgd_pkg::*;

  localparam int DW    = POS_W + 1;
  localparam int TRV_W = POS_W + $clog2(MAX_SAMPLES);
  localparam int CMP_W = TRV_W + 5;

  logic signed [POS_W-1:0] lo, hi, extreme;
  dir_t                    dir;
  logic [1:0]              revs;
  logic [TRV_W-1:0]        travel;

  logic signed [DW-1:0] d;
  logic [DW-1:0]        ad, span;
  logic [DW+3:0]        ad9, span9;
  logic                 big, rise, fall;
  logic [TRV_W-1:0]     travel_add;
  logic [CMP_W-1:0]     trv18, leg5, trv5, span8;

  always_comb begin
    d          = DW'(v) - DW'(extreme);
    ad         = d[DW-1] ? DW'(-d) : DW'(d);
    ad9        = (DW+4)'({ad, 3'b000}) + (DW+4)'(ad);
    big        = ad9 >= (DW+4)'(leg);
    rise       = !d[DW-1] && (d != '0);
    fall       = d[DW-1];
    travel_add = travel + TRV_W'(ad);
  end

  always_ff @(posedge clk) begin
    if (ctl.span) begin
      if (ctl.first) begin
        lo <= v;
        hi <= v;
      end else begin
        if (v < lo) lo <= v;
        if (v > hi) hi <= v;
      end
    end
    if (ctl.trk) begin
      if (ctl.first) begin
        extreme <= v;
        dir     <= DIR_NONE;
        revs    <= '0;
        travel  <= '0;
      end else begin
        case (dir)
          DIR_NONE: begin
            if (big) begin
              dir     <= fall ? DIR_DOWN : DIR_UP;
              travel  <= travel_add;
              extreme <= v;
            end
          end
          DIR_UP: begin
            if (rise) begin
              travel  <= travel_add;
              extreme <= v;
            end else if (big) begin
              if (revs < 2'(MIN_REVS)) revs <= revs + 2'd1;
              dir     <= DIR_DOWN;
              travel  <= travel_add;
              extreme <= v;
            end
          end
          DIR_DOWN: begin
            if (fall) begin
              travel  <= travel_add;
              extreme <= v;
            end else if (big) begin
              if (revs < 2'(MIN_REVS)) revs <= revs + 2'd1;
              dir     <= DIR_UP;
              travel  <= travel_add;
              extreme <= v;
            end
          end
          default: begin
            dir <= DIR_NONE;
          end
        endcase
      end
    end
  end

  // span and travel tests; the leg comparisons are in 1/144 px
  always_comb begin
    span  = DW'(hi) - DW'(lo);
    span9 = (DW+4)'({span, 3'b000}) + (DW+4)'(span);
    trv18 = CMP_W'({travel, 4'b0000}) + CMP_W'({travel, 1'b0});
    leg5  = CMP_W'({leg, 2'b00}) + CMP_W'(leg);
    trv5  = CMP_W'({travel, 2'b00}) + CMP_W'(travel);
    span8 = CMP_W'({span, 3'b000});
    ok    = (span9 >= (DW+4)'(leg)) && (revs >= 2'(MIN_REVS)) &&
            (trv18 >= leg5) && (trv5 >= span8);
  end
endmodule

>>> hw/rtl/pointer_shake_gesture_detector.sv
// channel   dir  handshake      word
// -------   ---  -------------  ------------------------------------------
// cfg       in   valid/ready    index, data (ready held high)
// sample    in   valid/ready    command, pos_x, pos_y, time_ms, eligible
// result    out  valid/ready    shake_detected
//
// A start writes the first entry; a skipped update goes straight to the
// result. A full update checks the distance to the newest entry, prunes,
// appends, trims the window, then runs span and tracker passes; too few
// window samples end it after the trim. The single read port of the history
// RAM takes one entry per cycle on each pass. Reset is synchronous and needs
// no clearing pass. A new word is taken while a result waits in the output
// register; the next result then waits for the output to drain.
module pointer_shake_gesture_detector #(
  parameter int MAX_SAMPLES = 48
) (
  input logic       clk,
  input logic       rst,
  psgd_cfg_if.sink  cfg,
  psgd_in_if.sink   sample,
  psgd_out_if.source result
);
  import psgd_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = IW + 1;
  localparam int EW = TIME_W + 2 * POS_W;

  state_t state, state_next;

  logic [IW-1:0]       head;
  logic [CW-1:0]       count;
  logic                done;
  logic                en;
  logic [SENS_W-1:0]   sens;
  logic [WIN_W-1:0]    win;
  logic                out_valid;
  logic                out_bit;

  logic                cmd;
  logic signed [POS_W-1:0] px, py;
  logic [TIME_W-1:0]   now;
  logic                add;
  logic [TIME_W-1:0]   last_t;
  logic [CW-1:0]       first;
  logic [CW-1:0]       k;
  logic [NEAR_W-1:0]   dxs, dys;
  logic                far;
  logic                res;

  logic                we;
  logic [IW-1:0]       waddr, raddr;
  logic [EW-1:0]       wdata, rdata;
  axis_ctl_t           ctl;

  logic                    acc;
  logic signed [POS_W-1:0] rx, ry;
  logic [TIME_W-1:0]       rt;
  logic [POS_W:0]          adx, ady;
  logic signed [POS_W:0]   dx, dy;
  logic [DSQ_W-1:0]        dist_sq;
  logic                    prune_hit, win_hit, too_few, full, out_free;
  logic [IW-1:0]           h1;
  logic [CW-1:0]           c1, win_len;
  logic [LEG_W-1:0]        leg;
  logic                    ok_x, ok_y;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [CW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(MAX_SAMPLES)) sum = sum - SW'(MAX_SAMPLES);
    return sum[IW-1:0];
  endfunction

  psgd_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SAMPLES)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  psgd_axis #(.MAX_SAMPLES(MAX_SAMPLES)) u_axis_x (
    .clk (clk),
    .ctl (ctl),
    .v   (rx),
    .leg (leg),
    .ok  (ok_x)
  );

  psgd_axis #(.MAX_SAMPLES(MAX_SAMPLES)) u_axis_y (
    .clk (clk),
    .ctl (ctl),
    .v   (ry),
    .leg (leg),
    .ok  (ok_y)
  );

  always_comb begin
    acc       = sample.valid && sample.ready;
    rx        = rdata[POS_W-1:0];
    ry        = rdata[2*POS_W-1:POS_W];
    rt        = rdata[EW-1:2*POS_W];
    leg       = leg_of(sens);
    dx        = (POS_W+1)'(px) - (POS_W+1)'(rx);
    dy        = (POS_W+1)'(py) - (POS_W+1)'(ry);
    adx       = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
    ady       = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
    dist_sq   = DSQ_W'(dxs * dxs) + DSQ_W'(dys * dys);
    // drop the oldest entry while over 1 s old, unless it is the last and no add
    prune_hit = (count != '0) && ((count > CW'(1)) || add) &&
                ((now - rt) > TIME_W'(AGE_MS));
    win_hit   = ((first + CW'(1)) < count) &&
                ((last_t - rt) > TIME_W'(win_clamp(win)));
    win_len   = count - first;
    too_few   = win_len < CW'(MIN_WIN_SAMPLES);
    full      = count == CW'(MAX_SAMPLES);
    h1        = full ? slot(head, CW'(1)) : head;
    c1        = full ? CW'(MAX_SAMPLES - 1) : count;
    out_free  = !out_valid || result.ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (!sample.command) state_next = ST_START;
          else if (!en || done || !sample.eligible) state_next = ST_FINISH;
          else if (count == '0) state_next = ST_PRUNE;
          else state_next = ST_NEWEST;
        end
      end
      ST_START:  state_next = ST_FINISH;
      ST_NEWEST: state_next = ST_DIST;
      ST_DIST:   state_next = ST_PRUNE;
      ST_PRUNE: begin
        if (!prune_hit) state_next = ST_APPEND;
      end
      ST_APPEND: state_next = ST_WIN0;
      ST_WIN0:   state_next = ST_WIN;
      ST_WIN: begin
        if (!win_hit) state_next = too_few ? ST_FINISH : ST_SPAN0;
      end
      ST_SPAN0:  state_next = ST_SPAN;
      ST_SPAN: begin
        if ((k + CW'(1)) == count) state_next = ST_TRK0;
      end
      ST_TRK0:   state_next = ST_TRK;
      ST_TRK: begin
        if ((k + CW'(1)) == count) state_next = ST_EVAL;
      end
      ST_EVAL:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = 1'b0;
    raddr        = head;
    we           = 1'b0;
    waddr        = slot(h1, c1);
    wdata        = {now, py, px};
    ctl          = '0;
    unique case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        raddr        = slot(head, count - CW'(1));
      end
      ST_START: begin
        we    = 1'b1;
        waddr = '0;
      end
      ST_PRUNE:  raddr = slot(head, CW'(1));
      ST_APPEND: we = add;
      ST_WIN0:   raddr = slot(head, first);
      ST_WIN:    raddr = slot(head, first + CW'(1));
      ST_SPAN0:  raddr = slot(head, first);
      ST_SPAN: begin
        raddr     = slot(head, k + CW'(1));
        ctl.span  = 1'b1;
        ctl.first = (k == first);
      end
      ST_TRK0:   raddr = slot(head, first);
      ST_TRK: begin
        raddr     = slot(head, k + CW'(1));
        ctl.trk   = 1'b1;
        ctl.first = (k == first);
      end
      default: ;
    endcase
  end

  assign cfg.ready             = 1'b1;
  assign result.valid          = out_valid;
  assign result.shake_detected = out_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      done      <= 1'b0;
      en        <= EN_RST;
      sens      <= SENS_RST;
      win       <= WIN_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_ENABLE: en <= cfg.data[0];
          REG_SENS:   sens <= cfg.data[SENS_W-1:0];
          REG_WINDOW: win <= cfg.data[WIN_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_START: begin
          head  <= '0;
          count <= CW'(1);
          done  <= 1'b0;
        end
        ST_PRUNE: begin
          if (prune_hit) begin
            head  <= slot(head, CW'(1));
            count <= count - CW'(1);
          end
        end
        ST_APPEND: begin
          if (add) begin
            head  <= h1;
            count <= c1 + CW'(1);
          end
        end
        ST_EVAL: begin
          if (ok_x || ok_y) done <= 1'b1;
        end
        default: ;
      endcase
      if ((state == ST_FINISH) && out_free) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (acc) begin
          cmd <= sample.command;
          px  <= sample.pos_x;
          py  <= sample.pos_y;
          now <= sample.time_ms;
          add <= 1'b1;
          res <= 1'b0;
        end
      end
      ST_NEWEST: begin
        far    <= (adx >= (POS_W+1)'(NEAR_LIM)) || (ady >= (POS_W+1)'(NEAR_LIM));
        dxs    <= adx[NEAR_W-1:0];
        dys    <= ady[NEAR_W-1:0];
        last_t <= rt;
      end
      ST_DIST: begin
        add <= far || (dist_sq >= DSQ_W'(DIST_SQ));
      end
      ST_APPEND: begin
        if (add) last_t <= now;
        first <= '0;
      end
      ST_WIN: begin
        if (win_hit) first <= first + CW'(1);
      end
      ST_SPAN0, ST_TRK0: begin
        k <= first;
      end
      ST_SPAN, ST_TRK: begin
        k <= k + CW'(1);
      end
      ST_EVAL: begin
        res <= (ok_x || ok_y) && cmd;
      end
      default: ;
    endcase
    if ((state == ST_FINISH) && out_free) out_bit <= res;
  end
endmodule

>>> tb/sv/pointer_shake_gesture_detector_tb.sv
module pointer_shake_gesture_detector_tb;
  import psgd_pkg::*;

  localparam int TRAIL_DEPTH   = 48;
  localparam int SETTLE_CYCLES = 256;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int PHASES        = 8;

  typedef enum bit {
    CMD_START,
    CMD_UPDATE
  } cmd_t;

  typedef struct {
    bit                      command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TIME_W-1:0]       time_ms;
    bit                      eligible;
  } ptr_word_t;

  logic clk;
  logic rst;

  psgd_cfg_if cfg_ch ();
  psgd_in_if  sample_ch ();
  psgd_out_if result_ch ();

  pointer_shake_gesture_detector #(
    .MAX_SAMPLES(TRAIL_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .sample(sample_ch),
    .result(result_ch)
  );

  // predictor state
  bit                      cfg_enable = 1'b1;
  logic [SENS_W-1:0]       cfg_sens   = 4'd5;
  logic [WIN_W-1:0]        cfg_window = 10'd400;
  logic signed [POS_W-1:0] trail_x [TRAIL_DEPTH];
  logic signed [POS_W-1:0] trail_y [TRAIL_DEPTH];
  logic [TIME_W-1:0]       trail_t [TRAIL_DEPTH];
  int                      trail_head = 0;
  int                      trail_count = 0;
  bit                      shake_latched = 1'b0;

  ptr_word_t         word_q [$];
  bit                shake_exp_q [$];
  ptr_word_t         cur_word;
  bit                in_flight = 1'b0;
  bit                want_shake;
  int                stim_n = 0;
  logic [TIME_W-1:0] last_t = '0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                mismatch_n = 0;
  int                cycle_n = 0;

  function automatic longint trail_pos(bit on_y, int k);
    int i;
    i = (trail_head + k) % TRAIL_DEPTH;
    return on_y ? longint'(trail_y[i]) : longint'(trail_x[i]);
  endfunction

  // leg-hysteresis reversal tracker on one axis, positions scaled by 9 against the leg
  function automatic bit axis_shakes(bit on_y, int first, longint leg);
    longint lo, hi, v, ext, span, trav, d, ad;
    dir_t   dir;
    int     k, revs;
    lo = trail_pos(on_y, first);
    hi = lo;
    for (k = first + 1; k < trail_count; k++) begin
      v = trail_pos(on_y, k);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    end
    span = hi - lo;
    if (9 * span < leg) return 1'b0;
    ext  = trail_pos(on_y, first);
    dir  = DIR_NONE;
    revs = 0;
    trav = 0;
    for (k = first + 1; k < trail_count; k++) begin
      v = trail_pos(on_y, k);
      case (dir)
        DIR_NONE: begin
          d  = v - ext;
          ad = (d < 0) ? -d : d;
          if (9 * ad >= leg) begin
            dir  = (d > 0) ? DIR_UP : DIR_DOWN;
            trav += ad;
            ext  = v;
          end
        end
        DIR_UP: begin
          if (v > ext) begin
            trav += v - ext;
            ext  = v;
          end else if (9 * (ext - v) >= leg) begin
            revs++;
            dir  = DIR_DOWN;
            trav += ext - v;
            ext  = v;
          end
        end
        default: begin
          if (v < ext) begin
            trav += ext - v;
            ext  = v;
          end else if (9 * (v - ext) >= leg) begin
            revs++;
            dir  = DIR_UP;
            trav += v - ext;
            ext  = v;
          end
        end
      endcase
    end
    return revs >= MIN_REVS && 18 * trav >= 5 * leg && 5 * trav >= 8 * span;
  endfunction

  function automatic bit predict_shake(ptr_word_t w);
    longint            dx, dy, leg;
    bit                add;
    int                i, first, s, win;
    logic [TIME_W-1:0] age, newest_t;
    if (w.command == CMD_START) begin
      trail_head    = 0;
      trail_count   = 1;
      trail_x[0]    = w.pos_x;
      trail_y[0]    = w.pos_y;
      trail_t[0]    = w.time_ms;
      shake_latched = 1'b0;
      return 1'b0;
    end
    if (!cfg_enable || shake_latched || !w.eligible) return 1'b0;

    add = (trail_count == 0);
    if (!add) begin
      i   = (trail_head + trail_count - 1) % TRAIL_DEPTH;
      dx  = longint'(w.pos_x) - longint'(trail_x[i]);
      dy  = longint'(w.pos_y) - longint'(trail_y[i]);
      add = (dx * dx + dy * dy >= DIST_SQ);
    end
    // the pending sample counts toward the size when aging out
    while (trail_count > 0 && trail_count + int'(add) > 1) begin
      age = w.time_ms - trail_t[trail_head];
      if (age <= AGE_MS) break;
      trail_head = (trail_head + 1) % TRAIL_DEPTH;
      trail_count--;
    end
    if (add) begin
      if (trail_count >= TRAIL_DEPTH) begin
        trail_head  = (trail_head + 1) % TRAIL_DEPTH;
        trail_count = TRAIL_DEPTH - 1;
      end
      i          = (trail_head + trail_count) % TRAIL_DEPTH;
      trail_x[i] = w.pos_x;
      trail_y[i] = w.pos_y;
      trail_t[i] = w.time_ms;
      trail_count++;
    end

    win = int'(cfg_window);
    if (win < 150) win = 150;
    if (win > 1000) win = 1000;
    s = int'(cfg_sens);
    if (s < 1) s = 1;
    if (s > 10) s = 10;
    // 54 px at sensitivity 1, 40/9 px shorter per step, in 1/144 px
    leg = 7776 - 640 * (s - 1);

    newest_t = trail_t[(trail_head + trail_count - 1) % TRAIL_DEPTH];
    first    = 0;
    while (first + 1 < trail_count) begin
      age = newest_t - trail_t[(trail_head + first) % TRAIL_DEPTH];
      if (age <= win) break;
      first++;
    end
    if (trail_count - first < MIN_WIN_SAMPLES) return 1'b0;
    if (axis_shakes(1'b0, first, leg) || axis_shakes(1'b1, first, leg)) begin
      shake_latched = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic queue_word(bit cmd, int x, int y, logic [TIME_W-1:0] t, bit elig);
    ptr_word_t w;
    w.command  = cmd;
    w.pos_x    = POS_W'(x);
    w.pos_y    = POS_W'(y);
    w.time_ms  = t;
    w.eligible = elig;
    word_q.push_back(w);
    last_t = t;
    stim_n++;
  endtask

  // start plus a triangle wave on x, y or both, with jitter, creep and time glitches
  task automatic gen_shake();
    int                n, amp, steps, axis, dt_max, cx, cy, k, pos, off, x, y, jx, jy;
    logic [TIME_W-1:0] t;
    bit                elig;
    if ($urandom_range(3) == 0) begin
      n      = $urandom_range(30, 60);
      dt_max = $urandom_range(3, 20);
    end else begin
      n      = $urandom_range(5, 16);
      dt_max = $urandom_range(8, 90);
    end
    amp   = $urandom_range(120, 1400);
    steps = $urandom_range(1, 3);
    axis  = $urandom_range(2);
    cx    = int'($urandom_range(1040000)) - 520000;
    cy    = int'($urandom_range(1040000)) - 520000;
    t     = $urandom();
    x     = cx;
    y     = cy;
    queue_word(CMD_START, x, y, t, $urandom_range(1));
    for (k = 1; k < n; k++) begin
      pos = k % (2 * steps);
      off = (pos <= steps) ? amp * pos / steps : amp * (2 * steps - pos) / steps;
      jx  = int'($urandom_range(40)) - 20;
      jy  = int'($urandom_range(40)) - 20;
      if ($urandom_range(14) == 0) begin
        x = x + int'($urandom_range(30)) - 15;
      end else begin
        x = cx + jx + ((axis != 1) ? off : 0);
        y = cy + jy + ((axis != 0) ? off : 0);
      end
      case ($urandom_range(29))
        0:       t = t + 1001 + $urandom_range(500);
        1:       t = t - $urandom_range(1, 120);
        default: t = t + $urandom_range(1, dt_max);
      endcase
      elig = ($urandom_range(19) != 0);
      queue_word(CMD_UPDATE, x, y, t, elig);
    end
  endtask

  task automatic gen_noise();
    int                k, n;
    logic [TIME_W-1:0] t;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      t = ($urandom_range(1) == 0) ? $urandom() : last_t + $urandom_range(200);
      queue_word(($urandom_range(4) == 0) ? CMD_START : CMD_UPDATE,
                 int'($urandom()), int'($urandom()), t, $urandom_range(1));
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ENABLE: cfg_enable = val[0];
      REG_SENS:   cfg_sens   = val[SENS_W-1:0];
      REG_WINDOW: cfg_window = val[WIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (in_flight || word_q.size() != 0 || shake_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // driver: hold each word until taken, then predict it
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        shake_exp_q.push_back(predict_shake(cur_word));
        in_flight = 1'b0;
      end
      if (!in_flight && word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_word           = word_q.pop_front();
        in_flight          = 1'b1;
        sample_ch.command  <= cur_word.command;
        sample_ch.pos_x    <= cur_word.pos_x;
        sample_ch.pos_y    <= cur_word.pos_y;
        sample_ch.time_ms  <= cur_word.time_ms;
        sample_ch.eligible <= cur_word.eligible;
      end
      sample_ch.valid <= in_flight;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (shake_exp_q.size() == 0) begin
          mismatch_n++;
          if (mismatch_n <= 10)
            $display("unexpected result word: shake_detected=%0b", result_ch.shake_detected);
        end else begin
          want_shake = shake_exp_q.pop_front();
          if (result_ch.shake_detected !== want_shake) begin
            mismatch_n++;
            if (mismatch_n <= 10)
              $display("shake_detected mismatch: expected %0b, got %0b",
                       want_shake, result_ch.shake_detected);
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int                    ph, target;
    bit                    en;
    logic [SENS_W-1:0]     sens;
    logic [WIN_W-1:0]      win;
    rst                = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    sample_ch.valid    = 1'b0;
    sample_ch.command  = 1'b0;
    sample_ch.pos_x    = '0;
    sample_ch.pos_y    = '0;
    sample_ch.time_ms  = '0;
    sample_ch.eligible = 1'b0;
    result_ch.ready    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // update before any start, then an x shake across the time wrap
    queue_word(CMD_UPDATE, 524287, -524288, 32'hFFFF_FFC0, 1'b1);
    queue_word(CMD_START, -524288, 524287, 32'hFFFF_FFE0, 1'b1);
    queue_word(CMD_UPDATE, -523288, 524287, 32'hFFFF_FFF8, 1'b1);
    queue_word(CMD_UPDATE, -524288, 524287, 32'h0000_0010, 1'b1);
    queue_word(CMD_UPDATE, -523288, 524287, 32'h0000_0028, 1'b1);
    queue_word(CMD_UPDATE, -524288, 524287, 32'h0000_0040, 1'b1);
    // not eligible, sub-2px move, exact 2px move, time going back, stale gap
    queue_word(CMD_START, 0, 0, 1000, 1'b0);
    queue_word(CMD_UPDATE, 5000, 0, 1010, 1'b0);
    queue_word(CMD_UPDATE, 31, 0, 1020, 1'b1);
    queue_word(CMD_UPDATE, 0, 32, 1030, 1'b1);
    queue_word(CMD_UPDATE, 0, -600, 1020, 1'b1);
    queue_word(CMD_UPDATE, 0, 32, 3000, 1'b1);
    queue_word(CMD_UPDATE, 0, -600, 3020, 1'b1);
    queue_word(CMD_UPDATE, 0, 32, 3040, 1'b1);
    queue_word(CMD_UPDATE, 0, -600, 3060, 1'b1);
    // legs one unit short of the default minimum
    queue_word(CMD_START, 0, 0, 5000, 1'b1);
    queue_word(CMD_UPDATE, 579, 0, 5020, 1'b1);
    queue_word(CMD_UPDATE, 0, 0, 5040, 1'b1);
    queue_word(CMD_UPDATE, 579, 0, 5060, 1'b1);
    queue_word(CMD_UPDATE, 0, 0, 5080, 1'b1);
    wait_drain();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      en   = 1'b1;
      sens = $urandom_range(15);
      win  = $urandom_range(1023);
      case (ph)
        0: begin sens = 4'd1;  win = 10'd150;  end
        1: begin sens = 4'd10; win = 10'd1000; end
        2: begin sens = 4'd0;  win = 10'd0;    end
        3: begin sens = 4'd15; win = 10'd1023; end
        4: en = 1'b0;
        6: begin sens = 4'd5;  win = 10'd400;  end
        default: ;
      endcase
      cfg_write(REG_ENABLE, CFG_DATA_W'(en));
      cfg_write(REG_SENS, CFG_DATA_W'(sens));
      cfg_write(REG_WINDOW, CFG_DATA_W'(win));
      target = stim_n + ((ph == 4) ? 30 : 140);
      while (stim_n < target) begin
        if ($urandom_range(3) != 0) gen_shake();
        else gen_noise();
      end
      wait_drain();
    end

    if (mismatch_n == 0 && shake_exp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
